// File: hw/rtl/drpi_pkg.sv
// Shared types, widths and constants of the dead-reckoning pose integrator.
package drpi_pkg;

  // Fixed field widths
  localparam int SPEED_W    = 16;
  localparam int YAW_W      = 16;
  localparam int CFG_W      = 16;
  localparam int POSE_W     = 32;
  localparam int IN_DATA_W  = 4 * SPEED_W + YAW_W;
  localparam int OUT_DATA_W = 2 * POSE_W + YAW_W;

  // Design constants
  localparam int CORDIC_STEPS = 16;   // 8 .. 24
  localparam int POS_W        = 32;   // 24 .. 48
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam logic [CFG_W-1:0] WHEEL_RADIUS_RST = 16'd3277;
  localparam logic [CFG_W-1:0] TIME_STEP_RST    = 16'd655;
  localparam logic [CFG_W-1:0] CORDIC_GAIN      = 16'd39797;

  // Datapath widths
  localparam int SUM_W   = SPEED_W + 2;          // sum of four speeds
  localparam int V_W     = 24;                   // S * radius >> 10
  localparam int VK_W    = 24;                   // v * gain >> 16
  localparam int XY_W    = 34;                   // rotation x and y, Q.24
  localparam int Z_W     = 33;                   // rotation angle
  localparam int MUL_A_W = XY_W;
  localparam int MUL_B_W = CFG_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DX_W    = PROD_W - 24;          // x * step >> 24
  localparam int ACC_SUM_W  = ((POS_W > DX_W) ? POS_W : DX_W) + 1;
  localparam int POSE_CALC_W = (POS_W > POSE_W) ? POS_W : POSE_W;

  // Register indices
  typedef enum logic [0:0] {
    REG_WHEEL_RADIUS = 1'b0,
    REG_TIME_STEP    = 1'b1
  } reg_idx_t;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_SEL_V = 2'd0,
    MUL_SEL_K = 2'd1,
    MUL_SEL_X = 2'd2,
    MUL_SEL_Y = 2'd3
  } mul_sel_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_V,
    ST_MUL_K,
    ST_LOAD,
    ST_ROTATE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ACC_Y,
    ST_OUT
  } state_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic                  in_ready;
    logic                  mul_en;
    mul_sel_t              mul_sel;
    logic                  cordic_load;
    logic                  cordic_step;
    logic [ATAN_IDX_W-1:0] step_idx;
    logic                  acc_x;
    logic                  acc_y;
    logic                  out_load;
  } ctrl_t;

  // Arctangent table, full circle = 2^32
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return signed'(Z_W'(a));
  endfunction

  // Saturate a widened position sum to the accumulator range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_SUM_W-1:0] s);
    logic signed [ACC_SUM_W-1:0] hi;
    logic signed [ACC_SUM_W-1:0] lo;
    logic signed [POS_W-1:0]     r;
    hi = ACC_SUM_W'(signed'({1'b0, {(POS_W-1){1'b1}}}));
    lo = ~hi;
    if (s > hi) begin
      r = hi[POS_W-1:0];
    end else if (s < lo) begin
      r = lo[POS_W-1:0];
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

  // Clamp the accumulator to the 32 bit pose range
  function automatic logic [POSE_W-1:0] pose_of(input logic signed [POS_W-1:0] p);
    logic signed [POSE_CALC_W-1:0] e;
    logic signed [POSE_CALC_W-1:0] hi;
    logic signed [POSE_CALC_W-1:0] lo;
    logic [POSE_W-1:0]             r;
    e  = POSE_CALC_W'(p);
    hi = POSE_CALC_W'(signed'({1'b0, {(POSE_W-1){1'b1}}}));
    lo = ~hi;
    if (e > hi) begin
      r = hi[POSE_W-1:0];
    end else if (e < lo) begin
      r = lo[POSE_W-1:0];
    end else begin
      r = e[POSE_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/drpi_mul.sv
// Shared signed multiplier with registered product.
module drpi_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [drpi_pkg::MUL_A_W-1:0]   a,
  input  logic signed [drpi_pkg::MUL_B_W-1:0]   b,
  output logic signed [drpi_pkg::PROD_W-1:0]    prod
);
  import drpi_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  // Form the product
  always_comb begin
    prod_nxt = prod_r;
    if (en) begin
      prod_nxt = a * b;
    end
  end

  // Hold the product
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// File: hw/rtl/drpi_cordic.sv
// Iterative CORDIC rotation: one micro-rotation per cycle while step is held high.
module drpi_cordic (
  input  logic                                     clk,
  input  logic                                     load,
  input  logic                                     step,
  input  logic [drpi_pkg::ATAN_IDX_W-1:0]          idx,
  input  logic signed [drpi_pkg::VK_W-1:0]         vk,
  input  logic signed [drpi_pkg::YAW_W-1:0]        yaw,
  output logic signed [drpi_pkg::XY_W-1:0]         x,
  output logic signed [drpi_pkg::XY_W-1:0]         y
);
  import drpi_pkg::*;

  logic signed [XY_W-1:0] x_r, x_nxt;
  logic signed [XY_W-1:0] y_r, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;

  logic signed [XY_W-1:0] x0;
  logic signed [Z_W-1:0]  z0;
  logic signed [Z_W-1:0]  quarter;
  logic signed [Z_W-1:0]  half;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  at;

  assign quarter = Z_W'(signed'({2'b01, 30'b0}));
  assign half    = Z_W'(signed'({2'b01, 31'b0}));
  assign x0      = XY_W'(vk) <<< 8;
  assign z0      = Z_W'(signed'({yaw, 16'b0}));

  // Shifted operands for this micro-rotation
  assign xs = y_r >>> idx;
  assign ys = x_r >>> idx;
  assign at = atan_lut(idx);

  // Fold the angle into the right half plane on load, rotate on step
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (load) begin
      y_nxt = '0;
      if (z0 > quarter) begin
        z_nxt = z0 - half;
        x_nxt = -x0;
      end else if (z0 < -quarter) begin
        z_nxt = z0 + half;
        x_nxt = -x0;
      end else begin
        z_nxt = z0;
        x_nxt = x0;
      end
    end else if (step) begin
      if (!z_r[Z_W-1]) begin
        x_nxt = x_r - xs;
        y_nxt = y_r + ys;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + xs;
        y_nxt = y_r - ys;
        z_nxt = z_r + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x = x_r;
  assign y = y_r;

endmodule

// File: hw/rtl/drpi_ctrl.sv
// Sequencer that steps one tick through the shared multiplier and CORDIC.
module drpi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  output drpi_pkg::ctrl_t   ctrl
);
  import drpi_pkg::*;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               last_step;

  assign last_step = (step_r == STEP_W'(CORDIC_STEPS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL_V;
      ST_MUL_V:  state_nxt = ST_MUL_K;
      ST_MUL_K:  state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_ROTATE;
      ST_ROTATE: if (last_step) state_nxt = ST_MUL_X;
      ST_MUL_X:  state_nxt = ST_MUL_Y;
      ST_MUL_Y:  state_nxt = ST_ACC_Y;
      ST_ACC_Y:  state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Advance the rotation counter
  always_comb begin
    step_nxt = step_r;
    if (state_r == ST_LOAD) begin
      step_nxt = '0;
    end else if (state_r == ST_ROTATE) begin
      step_nxt = step_r + 1'b1;
    end
  end

  // Outputs
  always_comb begin
    ctrl             = '0;
    ctrl.mul_sel     = MUL_SEL_V;
    ctrl.step_idx    = ATAN_IDX_W'(step_r);
    case (state_r)
      ST_IDLE:   ctrl.in_ready = 1'b1;
      ST_MUL_V:  begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_SEL_V;
      end
      ST_MUL_K:  begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_SEL_K;
      end
      ST_LOAD:   ctrl.cordic_load = 1'b1;
      ST_ROTATE: ctrl.cordic_step = 1'b1;
      ST_MUL_X:  begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_SEL_X;
      end
      ST_MUL_Y:  begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_SEL_Y;
        ctrl.acc_x   = 1'b1;
      end
      ST_ACC_Y:  ctrl.acc_y = 1'b1;
      ST_OUT:    ctrl.out_load = out_free;
      default:   ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: hw/rtl/dead_reckoning_pose_integrator_core.sv
// Top level of the dead-reckoning pose integrator.
//
// Each input word on in_* is one odometry tick: four signed Q8.8 wheel
// speeds and a binary-angle yaw. The block averages left and right wheels,
// scales by the wheel radius, rotates the forward speed by the yaw with an
// iterative CORDIC and adds speed times time_step into saturating Q16.16
// X and Y accumulators. Each tick yields one pose word on out_*.
// cfg_* writes wheel_radius (index 0) or time_step (index 1); it is always
// ready and is meant to be used only while no tick is in flight.
// A tick occupies the block through the CORDIC loop, which does one
// micro-rotation per cycle, and through four passes of the one shared
// multiplier. in_tready is high only while idle, so the next tick is not
// taken before the last one has been loaded into the output register.
// The output register holds a finished pose while the receiver stalls; the
// next tick may be taken and worked on, and waits at its end for the slot.
// Reset clears both accumulators and restores the register defaults.
module dead_reckoning_pose_integrator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // speed_left_front, speed_left_rear, speed_right_front, speed_right_rear, yaw_angle
  input  logic [drpi_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pose_x, pose_y, pose_heading
  output logic [drpi_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [drpi_pkg::CFG_W-1:0]         cfg_data
);
  import drpi_pkg::*;

  ctrl_t ctrl;

  logic [CFG_W-1:0]            wheel_radius_r, wheel_radius_nxt;
  logic [CFG_W-1:0]            time_step_r, time_step_nxt;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic signed [YAW_W-1:0]     yaw_r, yaw_nxt;
  logic signed [POS_W-1:0]     pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0]     pos_y_r, pos_y_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]       out_data_r, out_data_nxt;

  logic                        in_acc;
  logic                        out_free;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic signed [V_W-1:0]       v;
  logic signed [VK_W-1:0]      vk;
  logic signed [DX_W-1:0]      d;
  logic signed [XY_W-1:0]      cx;
  logic signed [XY_W-1:0]      cy;
  logic signed [SUM_W-1:0]     speed_sum;

  assign in_tready = ctrl.in_ready;
  assign in_acc    = in_tvalid && ctrl.in_ready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  drpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Sum the four wheel speeds
  assign speed_sum = SUM_W'(signed'(in_tdata[0*SPEED_W +: SPEED_W]))
                   + SUM_W'(signed'(in_tdata[1*SPEED_W +: SPEED_W]))
                   + SUM_W'(signed'(in_tdata[2*SPEED_W +: SPEED_W]))
                   + SUM_W'(signed'(in_tdata[3*SPEED_W +: SPEED_W]));

  // Capture the tick on accept
  always_comb begin
    sum_nxt = sum_r;
    yaw_nxt = yaw_r;
    if (in_acc) begin
      sum_nxt = speed_sum;
      yaw_nxt = signed'(in_tdata[4*SPEED_W +: YAW_W]);
    end
  end

  // Configuration writes
  always_comb begin
    wheel_radius_nxt = wheel_radius_r;
    time_step_nxt    = time_step_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_WHEEL_RADIUS: wheel_radius_nxt = cfg_data;
        REG_TIME_STEP:    time_step_nxt    = cfg_data;
        default:          wheel_radius_nxt = wheel_radius_r;
      endcase
    end
  end

  // Scaled fields of the product register
  assign v  = prod[10 +: V_W];
  assign vk = prod[16 +: VK_W];
  assign d  = prod[24 +: DX_W];

  // Select multiplier operands
  always_comb begin
    mul_a = MUL_A_W'(sum_r);
    mul_b = signed'({1'b0, wheel_radius_r});
    case (ctrl.mul_sel)
      MUL_SEL_V: begin
        mul_a = MUL_A_W'(sum_r);
        mul_b = signed'({1'b0, wheel_radius_r});
      end
      MUL_SEL_K: begin
        mul_a = MUL_A_W'(v);
        mul_b = signed'({1'b0, CORDIC_GAIN});
      end
      MUL_SEL_X: begin
        mul_a = cx;
        mul_b = signed'({1'b0, time_step_r});
      end
      MUL_SEL_Y: begin
        mul_a = cy;
        mul_b = signed'({1'b0, time_step_r});
      end
      default: begin
        mul_a = MUL_A_W'(sum_r);
        mul_b = signed'({1'b0, wheel_radius_r});
      end
    endcase
  end

  drpi_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  drpi_cordic u_cordic (
    .clk  (clk),
    .load (ctrl.cordic_load),
    .step (ctrl.cordic_step),
    .idx  (ctrl.step_idx),
    .vk   (vk),
    .yaw  (yaw_r),
    .x    (cx),
    .y    (cy)
  );

  // Accumulate position with saturation
  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (ctrl.acc_x) begin
      pos_x_nxt = sat_pos(ACC_SUM_W'(pos_x_r) + ACC_SUM_W'(d));
    end
    if (ctrl.acc_y) begin
      pos_y_nxt = sat_pos(ACC_SUM_W'(pos_y_r) + ACC_SUM_W'(d));
    end
  end

  // Output register: load a finished pose, drop it once taken
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_data_nxt  = {yaw_r, pose_of(pos_y_r), pose_of(pos_x_r)};
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_radius_r <= WHEEL_RADIUS_RST;
      time_step_r    <= TIME_STEP_RST;
      pos_x_r        <= '0;
      pos_y_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      wheel_radius_r <= wheel_radius_nxt;
      time_step_r    <= time_step_nxt;
      pos_x_r        <= pos_x_nxt;
      pos_y_r        <= pos_y_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    yaw_r      <= yaw_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

// File: test/dead_reckoning_pose_integrator_core_test.sv
// Self-checking stream testbench for the dead-reckoning pose integrator core.
`timescale 1ns / 100ps

module dead_reckoning_pose_integrator_core_test;
  import drpi_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam longint GAIN_Q16    = 39797;

  // One odometry tick, first field in the lowest bits
  typedef struct packed {
    logic signed [SPEED_W-1:0] yaw;
    logic signed [SPEED_W-1:0] rr;
    logic signed [SPEED_W-1:0] rf;
    logic signed [SPEED_W-1:0] lr;
    logic signed [SPEED_W-1:0] lf;
  } odo_tick_t;

  // One pose word, first field in the lowest bits
  typedef struct packed {
    logic signed [YAW_W-1:0]  heading;
    logic signed [POSE_W-1:0] y;
    logic signed [POSE_W-1:0] x;
  } pose_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;

  // Tick words waiting for the driver, poses waiting for the monitor
  odo_tick_t pending_ticks[$];
  pose_t     expected_poses[$];

  // Predictor copy of the registers and accumulators
  logic [CFG_W-1:0] radius_cfg = WHEEL_RADIUS_RST;
  logic [CFG_W-1:0] step_cfg   = TIME_STEP_RST;
  longint           pos_x_acc  = 0;
  longint           pos_y_acc  = 0;

  bit in_taken      = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int ticks_taken   = 0;
  int poses_checked = 0;
  int limit_hits    = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;

  dead_reckoning_pose_integrator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Arctangent of 2^-i, full circle = 2^32
  function automatic longint arctan_q32(int i);
    longint a;
    case (i)
      0:  a = 64'h20000000;
      1:  a = 64'h12E4051E;
      2:  a = 64'h09FB385B;
      3:  a = 64'h051111D4;
      4:  a = 64'h028B0D43;
      5:  a = 64'h0145D7E1;
      6:  a = 64'h00A2F61E;
      7:  a = 64'h00517C55;
      8:  a = 64'h0028BE53;
      9:  a = 64'h00145F2F;
      10: a = 64'h000A2F98;
      11: a = 64'h000517CC;
      12: a = 64'h00028BE6;
      13: a = 64'h000145F3;
      14: a = 64'h0000A2FA;
      15: a = 64'h0000517D;
      16: a = 64'h000028BE;
      17: a = 64'h0000145F;
      18: a = 64'h00000A30;
      19: a = 64'h00000518;
      20: a = 64'h0000028C;
      21: a = 64'h00000146;
      22: a = 64'h000000A3;
      23: a = 64'h00000051;
      default: a = 0;
    endcase
    return a;
  endfunction

  function automatic longint clamp_bits(longint val, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (val > hi) return hi;
    if (val < lo) return lo;
    return val;
  endfunction

  // Advance the dead-reckoning state by one tick and return the pose it yields
  function automatic pose_t advance_pose(odo_tick_t t);
    longint sum, v, vk, x, y, z, xs, ys;
    pose_t  p;
    sum = longint'(t.lf) + longint'(t.lr) + longint'(t.rf) + longint'(t.rr);
    v   = (sum * longint'(radius_cfg)) >>> 10;
    vk  = (v * GAIN_Q16) >>> 16;
    x   = vk * 256;
    y   = 0;
    z   = longint'(t.yaw) * 65536;
    // fold headings beyond a quarter turn back into range
    if (z > (longint'(1) <<< 30)) begin
      z -= longint'(1) <<< 31;
      x = -x;
    end else if (z < -(longint'(1) <<< 30)) begin
      z += longint'(1) <<< 31;
      x = -x;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (z >= 0) begin
        x -= xs;
        y += ys;
        z -= arctan_q32(i);
      end else begin
        x += xs;
        y -= ys;
        z += arctan_q32(i);
      end
    end
    pos_x_acc = clamp_bits(pos_x_acc + ((x * longint'(step_cfg)) >>> 24), POS_W);
    pos_y_acc = clamp_bits(pos_y_acc + ((y * longint'(step_cfg)) >>> 24), POS_W);
    p.x       = POSE_W'(clamp_bits(pos_x_acc, POSE_W));
    p.y       = POSE_W'(clamp_bits(pos_y_acc, POSE_W));
    p.heading = t.yaw;
    return p;
  endfunction

  function automatic odo_tick_t make_tick(int lf, int lr, int rf, int rr, int yaw);
    odo_tick_t t;
    t.lf  = SPEED_W'(lf);
    t.lr  = SPEED_W'(lr);
    t.rf  = SPEED_W'(rf);
    t.rr  = SPEED_W'(rr);
    t.yaw = YAW_W'(yaw);
    return t;
  endfunction

  // Near full speed along the diagonal towards +x, -y, half of it driven in
  // reverse with the heading turned half a circle
  function automatic odo_tick_t haul_tick();
    odo_tick_t t;
    int        jit;
    jit = int'($urandom_range(400)) - 200;
    if ($urandom_range(1) == 1) begin
      t = make_tick($urandom_range(32767, 32000), $urandom_range(32767, 32000),
                    $urandom_range(32767, 32000), $urandom_range(32767, 32000),
                    -8192 + jit);
    end else begin
      t = make_tick(-int'($urandom_range(32768, 32000)), -int'($urandom_range(32768, 32000)),
                    -int'($urandom_range(32768, 32000)), -int'($urandom_range(32768, 32000)),
                    24576 + jit);
    end
    return t;
  endfunction

  // Queue legs of steady driving with jitter, mixed with pure noise words
  task automatic push_legs(int n);
    odo_tick_t base;
    odo_tick_t t;
    int        left;
    int        run;
    left = n;
    while (left > 0) begin
      base = odo_tick_t'(IN_DATA_W'({$urandom(), $urandom(), $urandom()}));
      run  = $urandom_range(12, 1);
      if (run > left) run = left;
      repeat (run) begin
        t = base;
        if ($urandom_range(99) < 15) begin
          t = odo_tick_t'(IN_DATA_W'({$urandom(), $urandom(), $urandom()}));
        end else begin
          t.lf  += SPEED_W'($urandom_range(511) - 256);
          t.lr  += SPEED_W'($urandom_range(511) - 256);
          t.rf  += SPEED_W'($urandom_range(511) - 256);
          t.rr  += SPEED_W'($urandom_range(511) - 256);
          t.yaw += YAW_W'($urandom_range(1023) - 512);
        end
        pending_ticks.push_back(t);
      end
      left -= run;
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every tick is taken and every pose returned, then let the core settle
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_ticks.size() != 0 || in_tvalid || expected_poses.size() != 0);
    repeat (CORDIC_STEPS + 16) @(posedge clk);
  endtask

  // Driver: present tick words and toggle the receiver's ready
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_taken) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= pending_ticks.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: track register writes, predict on accept, check each pose word
  always @(posedge clk) begin
    pose_t got;
    pose_t want;
    in_taken = in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (reg_idx_t'(cfg_index))
          REG_WHEEL_RADIUS: radius_cfg = cfg_data;
          REG_TIME_STEP:    step_cfg   = cfg_data;
          default: ;
        endcase
      end
      if (in_taken) begin
        ticks_taken++;
        expected_poses.push_back(advance_pose(odo_tick_t'(in_tdata)));
      end
      if (out_tvalid && out_tready) begin
        got = pose_t'(out_tdata);
        if (expected_poses.size() == 0) begin
          $error("pose word with no tick outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_poses.pop_front();
          poses_checked++;
          if (want.x == 32'sh7FFFFFFF || want.x == 32'sh80000000 ||
              want.y == 32'sh7FFFFFFF || want.y == 32'sh80000000) begin
            limit_hits++;
          end
          if (got.x != want.x) begin
            $error("pose_x mismatch: expected %0d, got %0d", want.x, got.x);
            fail_count++;
          end
          if (got.y != want.y) begin
            $error("pose_y mismatch: expected %0d, got %0d", want.y, got.y);
            fail_count++;
          end
          if (got.heading != want.heading) begin
            $error("pose_heading mismatch: expected %0d, got %0d", want.heading, got.heading);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender idles a little, receiver often
    send_idle_pct = 11;
    recv_idle_pct = 46;

    // corner ticks at the reset register values
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(32767, 32767, 32767, 32767, 0));
    pending_ticks.push_back(make_tick(-32768, -32768, -32768, -32768, 0));
    pending_ticks.push_back(make_tick(32767, 32767, -32768, -32768, 0));
    pending_ticks.push_back(make_tick(32767, 32767, 32767, 32767, -32768));
    pending_ticks.push_back(make_tick(32767, 32767, 32767, 32767, 32767));
    // quarter-turn boundaries, on and just past the fold
    pending_ticks.push_back(make_tick(-32768, -32768, -32768, -32768, 16384));
    pending_ticks.push_back(make_tick(-32768, -32768, -32768, -32768, 16385));
    pending_ticks.push_back(make_tick(32767, 32767, 32767, 32767, -16384));
    pending_ticks.push_back(make_tick(32767, 32767, 32767, 32767, -16385));
    pending_ticks.push_back(make_tick(1000, 1000, 1000, 1000, 8192));
    pending_ticks.push_back(make_tick(1000, 1000, 1000, 1000, -8192));
    // tiny speeds, where floor rounding of negatives shows
    pending_ticks.push_back(make_tick(-1, -1, -1, -1, 1));
    pending_ticks.push_back(make_tick(1, 1, 1, 1, -1));
    // one wheel at a time
    pending_ticks.push_back(make_tick(32767, 0, 0, 0, 4096));
    pending_ticks.push_back(make_tick(0, -32768, 0, 0, -4096));
    pending_ticks.push_back(make_tick(0, 0, 32767, 0, 20000));
    pending_ticks.push_back(make_tick(0, 0, 0, -32768, -20000));
    pending_ticks.push_back(make_tick(-32768, 32767, -32768, 32767, 12345));
    pending_ticks.push_back(make_tick(21845, -21846, 21845, -21846, 21845));
    pending_ticks.push_back(make_tick(-21846, 21845, -21846, 21845, -21846));
    pending_ticks.push_back(make_tick(256, 256, 256, 256, 0));
    wait_quiet();

    // largest radius and step, long diagonal run towards both position limits
    write_reg(REG_WHEEL_RADIUS, 16'hFFFF);
    write_reg(REG_TIME_STEP, 16'hFFFF);
    repeat (205) pending_ticks.push_back(haul_tick());
    wait_quiet();

    // swap the idling between the two sides, and run on into both position limits
    send_idle_pct = 46;
    recv_idle_pct = 11;
    repeat (205) pending_ticks.push_back(haul_tick());
    wait_quiet();

    // zero radius, then zero step
    write_reg(REG_WHEEL_RADIUS, 16'h0000);
    write_reg(REG_TIME_STEP, CFG_W'($urandom()));
    push_legs(12);
    wait_quiet();
    write_reg(REG_WHEEL_RADIUS, CFG_W'($urandom()));
    write_reg(REG_TIME_STEP, 16'h0000);
    push_legs(12);
    wait_quiet();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_WHEEL_RADIUS, CFG_W'($urandom()));
    write_reg(REG_TIME_STEP, CFG_W'($urandom()));
    push_legs(48);
    wait_quiet();
    write_reg(REG_WHEEL_RADIUS, 16'hFFFF);
    write_reg(REG_TIME_STEP, CFG_W'($urandom_range(2000, 1)));
    push_legs(48);
    wait_quiet();

    if (expected_poses.size() != 0) begin
      $error("%0d poses never returned", expected_poses.size());
      fail_count++;
    end
    $display("Drove %0d ticks across %0d register writes, idling on either side then on none.",
             ticks_taken, reg_writes);
    $display("Checked %0d pose words, %0d at a position limit; %0d mismatches.",
             poses_checked, limit_hits, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
